/* sv/aho_corasick_byte_scanner_defines.svh */
// Assertion macros for the Aho-Corasick byte scanner.
// Used by the top level; expects clk and arst_n in scope.
`ifndef AHO_CORASICK_BYTE_SCANNER_DEFINES_SVH
`define AHO_CORASICK_BYTE_SCANNER_DEFINES_SVH

// same-cycle implication
`define ACBS_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define ACBS_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* sv/acbs_pkg.sv */
// Shared constants and types for the Aho-Corasick byte scanner.
// No dependencies.
package acbs_pkg;

	localparam int NODE_COUNT_DEF       = 256;
	localparam int OUTPUTS_PER_NODE_DEF = 8;
	localparam int PATTERN_COUNT_DEF    = 1024;

	localparam logic [2:0] OP_SCAN  = 3'd0;
	localparam logic [2:0] OP_EDGE  = 3'd1;
	localparam logic [2:0] OP_FAIL  = 3'd2;
	localparam logic [2:0] OP_OUT   = 3'd3;
	localparam logic [2:0] OP_START = 3'd4;

	localparam int OUT_ENTRY_W = 19; // valid, pattern id, length

	typedef struct packed {
		logic clearing;
		logic scanning;
	} acbs_status_t;

endpackage

/* sv/acbs_ram.sv */
// Single write port, single read port RAM with registered read data.
// No dependencies.
module acbs_ram #(
	parameter int AW    = 8,
	parameter int WIDTH = 8
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [(1<<AW)];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule

/* sv/acbs_ctrl.sv */
// Scan sequencer: table loads, clearing sweep, failure walk and output list emission.
// Depends on acbs_pkg; drives the three table RAMs.
module acbs_ctrl #(
	parameter int NODE_COUNT       = acbs_pkg::NODE_COUNT_DEF,
	parameter int OUTPUTS_PER_NODE = acbs_pkg::OUTPUTS_PER_NODE_DEF,
	parameter int PATTERN_COUNT    = acbs_pkg::PATTERN_COUNT_DEF,
	parameter int NW               = $clog2(NODE_COUNT),
	parameter int SW               = (OUTPUTS_PER_NODE > 1) ? $clog2(OUTPUTS_PER_NODE) : 1
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_tvalid,
	output logic                            s_tready,
	input  logic [47:0]                     s_tdata,
	input  logic [2:0]                      s_tuser,
	output logic                            m_tvalid,
	input  logic                            m_tready,
	output logic [79:0]                     m_tdata,
	output logic                            m_tlast,
	output logic                            edge_we,
	output logic [NW+7:0]                   edge_waddr,
	output logic [NW:0]                     edge_wdata,
	output logic [NW+7:0]                   edge_raddr,
	input  logic [NW:0]                     edge_rdata,
	output logic                            fail_we,
	output logic [NW-1:0]                   fail_waddr,
	output logic [NW-1:0]                   fail_wdata,
	output logic [NW-1:0]                   fail_raddr,
	input  logic [NW-1:0]                   fail_rdata,
	output logic                            out_we,
	output logic [NW+SW-1:0]                out_waddr,
	output logic [acbs_pkg::OUT_ENTRY_W-1:0] out_wdata,
	output logic [NW+SW-1:0]                out_raddr,
	input  logic [acbs_pkg::OUT_ENTRY_W-1:0] out_rdata,
	output acbs_pkg::acbs_status_t          status
);

	localparam int EAW = NW + 8;
	localparam int HW  = NW + 1;

	localparam logic [2:0] ST_CLR   = 3'd0;
	localparam logic [2:0] ST_IDLE  = 3'd1;
	localparam logic [2:0] ST_EDGE  = 3'd2;
	localparam logic [2:0] ST_ECHK  = 3'd3;
	localparam logic [2:0] ST_FCHK  = 3'd4;
	localparam logic [2:0] ST_ORD   = 3'd5;
	localparam logic [2:0] ST_OCHK  = 3'd6;
	localparam logic [2:0] ST_FLUSH = 3'd7;

	logic [2:0]     state_q;
	logic [EAW-1:0] clr_q;
	logic [NW-1:0]  cur_q;
	logic [7:0]     byte_q;
	logic [HW-1:0]  hops_q;
	logic [SW-1:0]  slot_q;
	logic [31:0]    pos_q;

	logic        pend_v_q;
	logic [31:0] pend_start_q;
	logic [31:0] pend_end_q;
	logic [9:0]  pend_pat_q;

	logic        m_tvalid_q;
	logic [79:0] m_tdata_q;
	logic        m_tlast_q;

	logic [7:0] in_byte, in_node, in_tgt, in_len;
	logic       in_ev;
	logic [2:0] in_slot;
	logic [9:0] in_pid;
	logic       accept;
	logic       node_ok, tgt_ok, slot_ok, pid_ok;
	logic [NW-1:0] node_n, tgt_n;

	logic          e_v;
	logic [NW-1:0] e_child;
	logic          o_v;
	logic [9:0]    o_pid;
	logic [7:0]    o_len;
	logic          out_free;
	logic          push;
	logic          push_last;
	logic          stall;

	assign in_byte = s_tdata[7:0];
	assign in_node = s_tdata[15:8];
	assign in_tgt  = s_tdata[23:16];
	assign in_ev   = s_tdata[24];
	assign in_slot = s_tdata[27:25];
	assign in_pid  = s_tdata[37:28];
	assign in_len  = s_tdata[45:38];

	assign s_tready = (state_q == ST_IDLE);
	assign accept   = s_tvalid && s_tready;

	assign node_ok = {9'd0, in_node} < 17'(NODE_COUNT);
	assign tgt_ok  = {9'd0, in_tgt} < 17'(NODE_COUNT);
	assign slot_ok = {4'd0, in_slot} < 7'(OUTPUTS_PER_NODE);
	assign pid_ok  = {7'd0, in_pid} < 17'(PATTERN_COUNT);
	assign node_n  = NW'(in_node);
	assign tgt_n   = NW'(in_tgt);

	assign e_v     = edge_rdata[NW];
	assign e_child = edge_rdata[NW-1:0];
	assign o_v     = out_rdata[18];
	assign o_pid   = out_rdata[17:8];
	assign o_len   = out_rdata[7:0];

	assign out_free = !m_tvalid_q || m_tready;

	always_comb begin
		edge_we    = 1'b0;
		edge_waddr = {node_n, in_byte};
		edge_wdata = in_ev ? {1'b1, tgt_n} : '0;
		fail_we    = 1'b0;
		fail_waddr = node_n;
		fail_wdata = tgt_n;
		out_we     = 1'b0;
		out_waddr  = {node_n, SW'(in_slot)};
		out_wdata  = in_ev ? {1'b1, in_pid, in_len} : '0;
		if (state_q == ST_CLR) begin
			edge_we    = 1'b1;
			edge_waddr = clr_q;
			edge_wdata = '0;
			fail_we    = 1'b1;
			fail_waddr = clr_q[NW-1:0];
			fail_wdata = '0;
			out_we     = 1'b1;
			out_waddr  = clr_q[NW+SW-1:0];
			out_wdata  = '0;
		end else if (accept) begin
			edge_we = (s_tuser == acbs_pkg::OP_EDGE) && node_ok && (!in_ev || tgt_ok);
			fail_we = (s_tuser == acbs_pkg::OP_FAIL) && node_ok && tgt_ok;
			out_we  = (s_tuser == acbs_pkg::OP_OUT) && node_ok && slot_ok && (!in_ev || pid_ok);
		end
	end

	assign edge_raddr = {cur_q, byte_q};
	assign fail_raddr = cur_q;
	assign out_raddr  = {cur_q, slot_q};

	always_comb begin
		stall     = (state_q == ST_OCHK) && o_v && pend_v_q && !out_free;
		push      = 1'b0;
		push_last = 1'b0;
		case (state_q)
			ST_OCHK: begin
				push = o_v && pend_v_q && out_free;
			end
			ST_FLUSH: begin
				push      = pend_v_q && out_free;
				push_last = 1'b1;
			end
			default: begin
				push = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_CLR;
			clr_q    <= '0;
			cur_q    <= '0;
			byte_q   <= '0;
			hops_q   <= '0;
			slot_q   <= '0;
			pos_q    <= '0;
			pend_v_q <= 1'b0;
		end else begin
			case (state_q)
				ST_CLR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == '1) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (accept) begin
						if (s_tuser == acbs_pkg::OP_START) begin
							cur_q <= '0;
							pos_q <= '0;
						end else if (s_tuser == acbs_pkg::OP_SCAN) begin
							byte_q  <= in_byte;
							hops_q  <= '0;
							state_q <= ST_EDGE;
						end
					end
				end
				ST_EDGE: begin
					state_q <= ST_ECHK;
				end
				ST_ECHK: begin
					slot_q <= '0;
					if (e_v) begin
						cur_q   <= e_child;
						state_q <= ST_ORD;
					end else if (cur_q == '0) begin
						state_q <= ST_ORD;
					end else if (hops_q >= HW'(NODE_COUNT)) begin
						cur_q   <= '0;
						state_q <= ST_EDGE;
					end else begin
						state_q <= ST_FCHK;
					end
				end
				ST_FCHK: begin
					cur_q   <= fail_rdata;
					hops_q  <= hops_q + 1'b1;
					state_q <= ST_EDGE;
				end
				ST_ORD: begin
					state_q <= ST_OCHK;
				end
				ST_OCHK: begin
					if (!stall) begin
						if (o_v) begin
							pend_v_q     <= 1'b1;
							pend_start_q <= pos_q - {24'd0, o_len} + 32'd1;
							pend_end_q   <= pos_q + 32'd1;
							pend_pat_q   <= o_pid;
						end
						if (slot_q == SW'(OUTPUTS_PER_NODE - 1)) begin
							state_q <= ST_FLUSH;
						end else begin
							slot_q  <= slot_q + 1'b1;
							state_q <= ST_ORD;
						end
					end
				end
				ST_FLUSH: begin
					if (!pend_v_q || out_free) begin
						pend_v_q <= 1'b0;
						pos_q    <= pos_q + 32'd1;
						state_q  <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (push) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			m_tdata_q <= {6'd0, pend_pat_q, pend_end_q, pend_start_q};
			m_tlast_q <= push_last;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tlast  = m_tlast_q;

	assign status.clearing = (state_q == ST_CLR);
	assign status.scanning = (state_q != ST_CLR) && (state_q != ST_IDLE);

endmodule

/* sv/aho_corasick_byte_scanner.sv */
// Channel  Group      Beat contents
// in       s_t*       tuser: op; tdata: byte, node, target, entry valid, slot, id, length
// out      m_t*       tdata: start, end, pattern; tlast: last match of the byte
// Load and start beats are taken in idle. A scan beat runs an edge probe (read, check),
// a failure hop and new probe per miss off the root, then reads the output list slot by
// slot and flushes, all bound by the single read port of each table. After reset a
// clearing sweep of all three tables runs with s_tready low. A stalled m_tready holds the scan.
// Depends on acbs_pkg, acbs_ram, acbs_ctrl and aho_corasick_byte_scanner_defines.svh.
`include "aho_corasick_byte_scanner_defines.svh"

module aho_corasick_byte_scanner #(
	parameter int NODE_COUNT       = acbs_pkg::NODE_COUNT_DEF,
	parameter int OUTPUTS_PER_NODE = acbs_pkg::OUTPUTS_PER_NODE_DEF,
	parameter int PATTERN_COUNT    = acbs_pkg::PATTERN_COUNT_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	// byte_value, node_id, target_node, entry_valid, output_slot, pattern_id,
	// pattern_length, zero pad
	input  logic [47:0] s_tdata,
	// op
	input  logic [2:0]  s_tuser,
	output logic        m_tvalid,
	input  logic        m_tready,
	// match_start, match_end, matched_pattern, zero pad
	output logic [79:0] m_tdata,
	output logic        m_tlast
);

	localparam int NW = $clog2(NODE_COUNT);
	localparam int SW = (OUTPUTS_PER_NODE > 1) ? $clog2(OUTPUTS_PER_NODE) : 1;
	localparam int OW = acbs_pkg::OUT_ENTRY_W;

	logic             edge_we;
	logic [NW+7:0]    edge_waddr, edge_raddr;
	logic [NW:0]      edge_wdata, edge_rdata;
	logic             fail_we;
	logic [NW-1:0]    fail_waddr, fail_wdata, fail_raddr, fail_rdata;
	logic             out_we;
	logic [NW+SW-1:0] out_waddr, out_raddr;
	logic [OW-1:0]    out_wdata, out_rdata;
	acbs_pkg::acbs_status_t status;

	acbs_ram #(.AW(NW + 8), .WIDTH(NW + 1)) u_edge_ram (
		.clk(clk), .we(edge_we), .waddr(edge_waddr), .wdata(edge_wdata),
		.raddr(edge_raddr), .rdata(edge_rdata)
	);

	acbs_ram #(.AW(NW), .WIDTH(NW)) u_fail_ram (
		.clk(clk), .we(fail_we), .waddr(fail_waddr), .wdata(fail_wdata),
		.raddr(fail_raddr), .rdata(fail_rdata)
	);

	acbs_ram #(.AW(NW + SW), .WIDTH(OW)) u_out_ram (
		.clk(clk), .we(out_we), .waddr(out_waddr), .wdata(out_wdata),
		.raddr(out_raddr), .rdata(out_rdata)
	);

	acbs_ctrl #(
		.NODE_COUNT(NODE_COUNT),
		.OUTPUTS_PER_NODE(OUTPUTS_PER_NODE),
		.PATTERN_COUNT(PATTERN_COUNT),
		.NW(NW),
		.SW(SW)
	) u_ctrl (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
		.edge_we(edge_we), .edge_waddr(edge_waddr), .edge_wdata(edge_wdata),
		.edge_raddr(edge_raddr), .edge_rdata(edge_rdata),
		.fail_we(fail_we), .fail_waddr(fail_waddr), .fail_wdata(fail_wdata),
		.fail_raddr(fail_raddr), .fail_rdata(fail_rdata),
		.out_we(out_we), .out_waddr(out_waddr), .out_wdata(out_wdata),
		.out_raddr(out_raddr), .out_rdata(out_rdata),
		.status(status)
	);

	`ACBS_ASSERT_NOW(a_no_table_write_in_scan, status.scanning, !edge_we && !fail_we && !out_we, "table write during scan")
	`ACBS_ASSERT_NOW(a_ready_only_idle, s_tready, !status.scanning && !status.clearing, "ready while busy")
	`ACBS_ASSERT_NEXT(a_scan_starts, s_tvalid && s_tready && s_tuser == acbs_pkg::OP_SCAN, status.scanning, "scan beat not started")

endmodule

/* bench/aho_corasick_byte_scanner_test.sv */
// Testbench for aho_corasick_byte_scanner: loads small automata, scans text and checks matches.
// Expected matches come from a behavioral automaton kept here; depends on acbs_pkg.
module aho_corasick_byte_scanner_test;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int NODES = acbs_pkg::NODE_COUNT_DEF;
	localparam int SLOTS = acbs_pkg::OUTPUTS_PER_NODE_DEF;
	localparam int PATS = acbs_pkg::PATTERN_COUNT_DEF;
	localparam int CYCLE_LIMIT = 900000;

	typedef struct packed {
		logic [2:0] op;
		logic [7:0] ch;
		logic [7:0] node;
		logic [7:0] target;
		logic       valid;
		logic [2:0] slot;
		logic [9:0] pid;
		logic [7:0] plen;
	} beat_t;

	typedef struct packed {
		logic [31:0] mstart;
		logic [31:0] mend;
		logic [9:0]  pat;
		logic        last;
	} match_t;

	typedef struct {
		beat_t b;
		logic  has_exp;
		match_t m;
	} row_t;

	logic clk = 0;
	logic arst_n = 0;
	logic s_tvalid = 0;
	logic s_tready;
	logic [47:0] s_tdata = '0;
	logic [2:0] s_tuser = '0;
	logic m_tvalid;
	logic m_tready = 0;
	logic [79:0] m_tdata;
	logic m_tlast;

	aho_corasick_byte_scanner i_dut (.*);

	always #6 clk = ~clk;

	logic [8:0]  goto_tab [NODES*256];
	logic [7:0]  fail_tab [NODES];
	logic [18:0] out_tab [NODES*SLOTS];
	logic [7:0]  cur_node;
	logic [31:0] text_pos;
	match_t pending_matches[$];
	int errors = 0;
	int cycles = 0;
	bit calm = 0;
	bit hold_long = 0;

	function automatic beat_t mk(logic [2:0] op, int ch, int node, int target, int valid,
			int slot, int pid, int plen);
		beat_t b;
		b.op = op; b.ch = 8'(ch); b.node = 8'(node); b.target = 8'(target);
		b.valid = 1'(valid);
		b.slot = 3'(slot); b.pid = 10'(pid); b.plen = 8'(plen);
		return b;
	endfunction

	function automatic void predict_matches(beat_t b);
		int hops;
		logic [7:0] c;
		int n;
		match_t m;
		case (b.op)
		acbs_pkg::OP_EDGE: begin
			if (!b.valid) goto_tab[{b.node, b.ch}] = '0;
			else goto_tab[{b.node, b.ch}] = {1'b1, b.target};
		end
		acbs_pkg::OP_FAIL: fail_tab[b.node] = b.target;
		acbs_pkg::OP_OUT: begin
			if (!b.valid) out_tab[{b.node, b.slot}] = '0;
			else out_tab[{b.node, b.slot}] = {1'b1, b.pid, b.plen};
		end
		acbs_pkg::OP_START: begin
			cur_node = '0;
			text_pos = '0;
		end
		acbs_pkg::OP_SCAN: begin
			c = cur_node;
			hops = 0;
			while (c != 0 && !goto_tab[{c, b.ch}][8]) begin
				if (hops >= NODES) begin
					c = '0;
					break;
				end
				c = fail_tab[c];
				hops++;
			end
			c = goto_tab[{c, b.ch}][8] ? goto_tab[{c, b.ch}][7:0] : 8'd0;
			cur_node = c;
			n = 0;
			for (int s = 0; s < SLOTS; s++) begin
				if (out_tab[{c, s[2:0]}][18]) begin
					m.mstart = text_pos - {24'd0, out_tab[{c, s[2:0]}][7:0]} + 32'd1;
					m.mend = text_pos + 32'd1;
					m.pat = out_tab[{c, s[2:0]}][17:8];
					m.last = 0;
					pending_matches = {pending_matches, m};
					n++;
				end
			end
			if (n > 0) pending_matches[$].last = 1;
			text_pos = text_pos + 32'd1;
		end
		default: ;
		endcase
	endfunction

	task automatic send(beat_t b);
		if (!calm && $urandom_range(0, 3) == 0) begin
			s_tvalid <= 0;
			repeat ($urandom_range(1, 17)) @(posedge clk);
		end
		s_tvalid <= 1;
		s_tuser <= b.op;
		s_tdata <= {5'd0, b.plen, b.pid, b.slot, b.valid, b.target, b.node, b.ch};
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		predict_matches(b);
	endtask

	task automatic idle_out();
		s_tvalid <= 0;
		while (pending_matches.size() > 0) @(posedge clk);
		repeat (40) @(posedge clk);
	endtask

	// receiver
	initial begin
		wait (arst_n);
		forever begin
			if (hold_long) begin
				m_tready <= 0;
				repeat (300) @(posedge clk);
				hold_long = 0;
			end else if (!calm && $urandom_range(0, 4) == 0) begin
				m_tready <= 0;
				repeat ($urandom_range(1, 17)) @(posedge clk);
			end else begin
				m_tready <= 1;
				@(posedge clk);
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			match_t got, want;
			got = {m_tdata[31:0], m_tdata[63:32], m_tdata[73:64], m_tlast};
			if (pending_matches.size() == 0) begin
				$display("%t unexpected match: got %h", $realtime, got);
				errors++;
			end else begin
				want = pending_matches.pop_front();
				if (got !== want) begin
					$display("%t mismatch: expected %h got %h", $realtime, want, got);
					errors++;
				end
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("status: fail");
			$finish;
		end
	end

	// small random automaton over letters a..d, nodes 0..8
	task automatic load_random_automaton();
		for (int n = 0; n < 9; n++) begin
			for (int c = "a"; c <= "d"; c++)
				send(mk(acbs_pkg::OP_EDGE, c, n, $urandom_range(1, 8),
					$urandom_range(0, 2) != 0, 0, 0, 0));
			send(mk(acbs_pkg::OP_FAIL, 0, n, $urandom_range(0, 8), $urandom_range(0, 1),
				0, 0, 0));
			for (int s = 0; s < 2; s++)
				send(mk(acbs_pkg::OP_OUT, 0, n, 0, $urandom_range(0, 1), $urandom_range(0, 7),
					$urandom_range(0, 1023), $urandom_range(0, 255)));
		end
	endtask

	row_t directed[$];

	initial begin
		row_t r;
		beat_t b;
		for (int i = 0; i < NODES*256; i++) goto_tab[i] = '0;
		for (int i = 0; i < NODES; i++) fail_tab[i] = '0;
		for (int i = 0; i < NODES*SLOTS; i++) out_tab[i] = '0;
		cur_node = '0;
		text_pos = '0;
		repeat (5) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		r.has_exp = 0;
		r.b = mk(acbs_pkg::OP_SCAN, 8'h00, 0, 0, 0, 0, 0, 0); directed = {directed, r};
		r.b = mk(acbs_pkg::OP_OUT, 0, 0, 0, 1, 7, 1023, 255); directed = {directed, r};
		r.b = mk(acbs_pkg::OP_SCAN, 8'hff, 0, 0, 0, 0, 0, 0);
		r.has_exp = 1; r.m = '{32'hffffff03, 32'd2, 10'd1023, 1'b1}; directed = {directed, r};
		r.has_exp = 0;
		r.b = mk(acbs_pkg::OP_OUT, 0, 0, 0, 0, 7, 0, 0); directed = {directed, r};
		r.b = mk(acbs_pkg::OP_EDGE, 8'hff, 0, 255, 1, 0, 0, 0); directed = {directed, r};
		r.b = mk(acbs_pkg::OP_EDGE, 8'h00, 255, 1, 1, 0, 0, 0); directed = {directed, r};
		r.b = mk(acbs_pkg::OP_FAIL, 0, 255, 0, 0, 0, 0, 0); directed = {directed, r};
		r.b = mk(acbs_pkg::OP_FAIL, 0, 1, 255, 1, 0, 0, 0); directed = {directed, r};
		r.b = mk(acbs_pkg::OP_OUT, 0, 255, 0, 1, 0, 0, 0); directed = {directed, r};
		r.b = mk(acbs_pkg::OP_OUT, 0, 1, 0, 1, 0, 5, 2); directed = {directed, r};
		r.b = mk(acbs_pkg::OP_OUT, 0, 1, 0, 1, 3, 6, 1); directed = {directed, r};
		r.b = mk(acbs_pkg::OP_START, 0, 0, 0, 0, 0, 0, 0); directed = {directed, r};
		r.b = mk(acbs_pkg::OP_SCAN, 8'hff, 0, 0, 0, 0, 0, 0);
		r.has_exp = 1; r.m = '{32'd1, 32'd1, 10'd0, 1'b1}; directed = {directed, r};
		r.has_exp = 0;
		r.b = mk(acbs_pkg::OP_SCAN, 8'h00, 0, 0, 0, 0, 0, 0); directed = {directed, r};
		r.b = mk(acbs_pkg::OP_SCAN, 8'h00, 0, 0, 0, 0, 0, 0); directed = {directed, r};
		r.b = mk(acbs_pkg::OP_EDGE, 8'h00, 255, 0, 0, 0, 0, 0); directed = {directed, r};
		r.b = mk(acbs_pkg::OP_FAIL, 0, 0, 1, 0, 0, 0, 0); directed = {directed, r};
		r.b = mk(acbs_pkg::OP_SCAN, 8'hff, 0, 0, 0, 0, 0, 0); directed = {directed, r};
		r.b = mk(acbs_pkg::OP_SCAN, 8'h55, 0, 0, 0, 0, 0, 0); directed = {directed, r};
		for (int op = 5; op <= 7; op++) begin
			r.b = mk(3'(op), 8'hff, 255, 255, 1, 7, 1023, 255); directed = {directed, r};
		end
		r.b = mk(acbs_pkg::OP_OUT, 0, 3, 0, 1, 2, 1023, 1); directed = {directed, r};

		foreach (directed[i]) begin
			int before_n;
			before_n = pending_matches.size();
			send(directed[i].b);
			if (directed[i].has_exp && (pending_matches.size() != before_n + 1
					|| pending_matches[$] !== directed[i].m)) begin
				$display("%t table row %0d: expected %h", $realtime, i, directed[i].m);
				errors++;
			end
		end
		idle_out();

		for (int round = 0; round < 2; round++) begin
			load_random_automaton();
			send(mk(acbs_pkg::OP_START, 0, 0, 0, 0, 0, 0, 0));
			if (round == 0) hold_long = 1;
			if (round == 1) calm = 1;
			for (int i = 0; i < 35; i++) begin
				b = mk(acbs_pkg::OP_SCAN, $urandom_range("a", "d"), 0, 0, 0, 0, 0, 0);
				if ($urandom_range(0, 9) == 0) b = beat_t'(51'({$urandom, $urandom}));
				if ($urandom_range(0, 29) == 0) b.ch = 8'($urandom_range(0, 255));
				send(b);
			end
			idle_out();
		end

		if (errors == 0) $display("status: pass");
		else $display("status: fail");
		$finish;
	end
endmodule

/* sim.f */
+incdir+sv
sv/acbs_pkg.sv
sv/acbs_ram.sv
sv/acbs_ctrl.sv
sv/aho_corasick_byte_scanner.sv
bench/aho_corasick_byte_scanner_test.sv
